// ===== hw/rtl/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg
// Types, codes and character decode helpers shared by the size string parser.
// ----------------------------------------------------------------------------
package ssp_pkg;

   localparam int VALUE_W  = 63;
   localparam int STATUS_W = 3;
   localparam int SHIFT_W  = 6;
   localparam int CHAR_W   = 8;
   localparam int RSP_W    = 72;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [VALUE_W-1:0] MAG_MAX = '1;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
   localparam logic [CHAR_W-1:0] CH_UC_A  = 8'd65;
   localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'd90;
   localparam logic [CHAR_W-1:0] CASE_GAP = 8'd32;

   typedef enum logic [2:0] {
      CLS_SPACE,
      CLS_PLUS,
      CLS_MINUS,
      CLS_DIGIT,
      CLS_UNIT,
      CLS_END,
      CLS_OTHER
   } char_class_type;

   typedef struct packed {
      char_class_type       cls;
      logic [3:0]           digit;
      logic [SHIFT_W-1:0]   shift;
   } char_token_type;

   typedef struct packed {
      logic                 hit;
      logic [SHIFT_W-1:0]   shift;
   } unit_type;

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_SIGN,
      PH_DIGITS,
      PH_UNIT,
      PH_BADSUF,
      PH_NODIG
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_NO_DIGITS,
      ST_NEGATIVE,
      ST_TOO_LARGE,
      ST_BAD_SUFFIX,
      ST_SCALE_OVF
   } status_type;

   function automatic unit_type unit_lookup(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] lc;
      unit_type          u;
      lc = (c >= CH_UC_A && c <= CH_UC_Z) ? c + CASE_GAP : c;
      u.hit = 1'b1;
      unique case (lc)
         "b":     u.shift = 6'd0;
         "k":     u.shift = 6'd10;
         "m":     u.shift = 6'd20;
         "g":     u.shift = 6'd30;
         "t":     u.shift = 6'd40;
         "p":     u.shift = 6'd50;
         "e":     u.shift = 6'd60;
         "s":     u.shift = 6'd9;
         default: begin
            u.hit   = 1'b0;
            u.shift = '0;
         end
      endcase
      return u;
   endfunction

endpackage

// ===== hw/rtl/ssp_front.sv =====
// ----------------------------------------------------------------------------
// ssp_front
// Classifies each incoming byte into a token for the parsing back end.
// ----------------------------------------------------------------------------
module ssp_front
   import ssp_pkg::*;
(
   input  logic [CHAR_W-1:0] char_code,
   output char_token_type    token
);

   unit_type unit;

   always_comb begin
      unit        = unit_lookup(char_code);
      token.cls   = CLS_OTHER;
      token.digit = char_code[3:0];
      token.shift = unit.shift;
      priority if (char_code == CH_NUL) begin
         token.cls = CLS_END;
      end else if ((char_code >= CH_TAB && char_code <= CH_CR) || char_code == CH_SPACE) begin
         token.cls = CLS_SPACE;
      end else if (char_code == CH_PLUS) begin
         token.cls = CLS_PLUS;
      end else if (char_code == CH_MINUS) begin
         token.cls = CLS_MINUS;
      end else if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
         token.cls = CLS_DIGIT;
      end else if (unit.hit) begin
         token.cls = CLS_UNIT;
      end else begin
         token.cls = CLS_OTHER;
      end
   end

endmodule

// ===== hw/rtl/ssp_queue.sv =====
// ----------------------------------------------------------------------------
// ssp_queue
// Short token queue between the classifier and the parsing back end.
// ----------------------------------------------------------------------------
module ssp_queue
   import ssp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_valid,
   output logic           wr_ready,
   input  char_token_type wr_data,
   output logic           rd_valid,
   input  logic           rd_ready,
   output char_token_type rd_data
);

   char_token_type        slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  push, pop;

   assign wr_ready = (count_ff != QUEUE_DEPTH[QUEUE_AW:0]);
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{QUEUE_AW{1'b0}}, push} - {{QUEUE_AW{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== hw/rtl/ssp_back.sv =====
// ----------------------------------------------------------------------------
// ssp_back
// Parsing state machine: gathers digits, applies the unit and drives results.
// ----------------------------------------------------------------------------
module ssp_back
   import ssp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                tok_valid,
   output logic                tok_ready,
   input  char_token_type      tok,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VALUE_W-1:0]  rsp_value,
   output status_type          rsp_status
);

   phase_type            phase_ff, phase_in;
   logic                 minus_ff, minus_in;
   logic [VALUE_W-1:0]   mag_ff, mag_in;
   logic                 ovf_ff, ovf_in;
   logic [SHIFT_W-1:0]   shift_ff, shift_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   status_type           rsp_status_ff, rsp_status_in;

   logic                 out_free;
   logic                 pop;
   logic                 take_digit;
   logic [VALUE_W+3:0]   mag_next;
   logic                 scale_ovf;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign tok_ready = (tok.cls != CLS_END) || out_free;
   assign pop       = tok_valid && tok_ready;

   // ten times plus digit, kept wide so that overflow shows in the top bits
   assign mag_next = {1'b0, mag_ff, 3'b000} + {3'b000, mag_ff, 1'b0}
                   + {{VALUE_W{1'b0}}, tok.digit};
   assign scale_ovf = |(mag_ff & ~(MAG_MAX >> shift_ff));

   always_comb begin
      phase_in      = phase_ff;
      minus_in      = minus_ff;
      mag_in        = mag_ff;
      ovf_in        = ovf_ff;
      shift_in      = shift_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      take_digit    = 1'b0;

      if (pop) begin
         if (tok.cls == CLS_END) begin
            rsp_valid_in = 1'b1;
            rsp_value_in = '0;
            priority if (phase_ff != PH_DIGITS && phase_ff != PH_UNIT && phase_ff != PH_BADSUF) begin
               rsp_status_in = ST_NO_DIGITS;
            end else if (minus_ff && (mag_ff != '0 || ovf_ff)) begin
               rsp_status_in = ST_NEGATIVE;
            end else if (ovf_ff) begin
               rsp_status_in = ST_TOO_LARGE;
            end else if (phase_ff == PH_BADSUF) begin
               rsp_status_in = ST_BAD_SUFFIX;
            end else if (scale_ovf) begin
               rsp_status_in = ST_SCALE_OVF;
            end else begin
               rsp_status_in = ST_OK;
               rsp_value_in  = mag_ff << shift_ff;
            end
            // back to the reset state for the next string
            phase_in = PH_SPACE;
            minus_in = 1'b0;
            mag_in   = '0;
            ovf_in   = 1'b0;
            shift_in = '0;
         end else begin
            unique case (phase_ff)
               PH_SPACE: begin
                  priority case (tok.cls)
                     CLS_SPACE: phase_in = PH_SPACE;
                     CLS_PLUS:  phase_in = PH_SIGN;
                     CLS_MINUS: begin
                        phase_in = PH_SIGN;
                        minus_in = 1'b1;
                     end
                     CLS_DIGIT: begin
                        phase_in   = PH_DIGITS;
                        take_digit = 1'b1;
                     end
                     default:   phase_in = PH_NODIG;
                  endcase
               end
               PH_SIGN: begin
                  if (tok.cls == CLS_DIGIT) begin
                     phase_in   = PH_DIGITS;
                     take_digit = 1'b1;
                  end else begin
                     phase_in = PH_NODIG;
                  end
               end
               PH_DIGITS: begin
                  priority if (tok.cls == CLS_DIGIT) begin
                     take_digit = 1'b1;
                  end else if (tok.cls == CLS_UNIT) begin
                     shift_in = tok.shift;
                     phase_in = PH_UNIT;
                  end else begin
                     phase_in = PH_BADSUF;
                  end
               end
               PH_UNIT:   phase_in = PH_BADSUF;
               PH_BADSUF: phase_in = PH_BADSUF;
               PH_NODIG:  phase_in = PH_NODIG;
               default:   phase_in = PH_NODIG;
            endcase

            // saturate once the magnitude runs past the top
            if (take_digit && !ovf_ff) begin
               if (mag_next[VALUE_W+3:VALUE_W] != '0) begin
                  ovf_in = 1'b1;
                  mag_in = MAG_MAX;
               end else begin
                  mag_in = mag_next[VALUE_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SPACE;
         minus_ff     <= 1'b0;
         mag_ff       <= '0;
         ovf_ff       <= 1'b0;
         shift_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         minus_ff     <= minus_in;
         mag_ff       <= mag_in;
         ovf_ff       <= ovf_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> mag_ff == MAG_MAX)
      else $error("overflow flag set without saturated magnitude");

   a_space_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SPACE |-> (mag_ff == '0 && !minus_ff && !ovf_ff))
      else $error("leading whitespace phase with stale state");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> rsp_value_ff == '0)
      else $error("error result with nonzero size");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (pop && tok.cls == CLS_END) |=> (phase_ff == PH_SPACE && rsp_valid_ff))
      else $error("string end did not restart parser or raise result");

endmodule

// ===== hw/rtl/size_string_parser_unit.sv =====
// ----------------------------------------------------------------------------
// size_string_parser_unit
// Parses a NUL-terminated decimal size string with an optional unit letter.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one ASCII byte per item in req_tdata[7:0]. Byte 0 ends the
//   string; only that byte produces an item on rsp_*, carrying the scaled size
//   in rsp_tdata[62:0] and a status code in rsp_tdata[65:63].
//   A classifier decodes each byte and pushes a token into a four-entry queue;
//   the parsing state machine pops one token per cycle unless a terminating
//   token waits on a full output register, and keeps the result in that register.
// Throughput: one byte per cycle, sustained, while rsp_tready allows.
// Result path: the terminating byte is written into the queue, then popped
//   by the state machine into the result register that drives rsp_tvalid;
//   any queued tokens ahead of it are parsed first.
// Stall: a result held by a low rsp_tready blocks the next terminating byte
//   at the queue head; bytes ahead of it keep being parsed, bytes behind it
//   wait, and req_tready drops once the queue fills.
// Reset: synchronous, clears the queue, the parser state and the result valid;
//   req_tready is high out of reset, as the queue starts empty.
// ----------------------------------------------------------------------------
module size_string_parser_unit
   import ssp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [CHAR_W-1:0] req_tdata,   // [7:0] char_code
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata     // [62:0] size_value, [65:63] status, zero pad
);

   char_token_type        front_token;
   char_token_type        queue_token;
   logic                  queue_valid;
   logic                  queue_ready;
   logic [VALUE_W-1:0]    size_value;
   status_type            status;

   ssp_front u_front (
      .char_code (req_tdata),
      .token     (front_token)
   );

   ssp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_tvalid),
      .wr_ready (req_tready),
      .wr_data  (front_token),
      .rd_valid (queue_valid),
      .rd_ready (queue_ready),
      .rd_data  (queue_token)
   );

   ssp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (queue_valid),
      .tok_ready  (queue_ready),
      .tok        (queue_token),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_value  (size_value),
      .rsp_status (status)
   );

   assign rsp_tdata = {{(RSP_W-VALUE_W-STATUS_W){1'b0}}, status, size_value};

endmodule
